// File: design/ors_pkg.sv
// ----------------------------------------------------------------------------
// ors_pkg
// shared types, constants and the crc-8 byte update for the rom search engine
// ----------------------------------------------------------------------------
package ors_pkg;

    localparam logic [7:0] CMD_SEARCH      = 8'hF0;
    localparam logic [7:0] CMD_COND_SEARCH = 8'hEC;
    localparam int         ROM_W           = 64;
    localparam int         POS_W           = 7;
    localparam int         IDX_W           = 6;

    typedef enum logic [2:0] {
        KIND_COMMAND = 3'd0,
        KIND_WRITE   = 3'd1,
        KIND_FOUND   = 3'd2,
        KIND_FAIL    = 3'd3,
        KIND_IGNORED = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       command_byte;
        logic             write_bit;
        logic [ROM_W-1:0] rom_id;
    } result_t;

    localparam logic [7:0] CRC_TERMS [8] = '{
        8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
    };

    function automatic logic [7:0] crc_byte(input logic [7:0] data, input logic [7:0] crc);
        logic [7:0] mix;
        logic [7:0] acc;
        mix = data ^ crc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (mix[i])
            begin
                acc = acc ^ CRC_TERMS[i];
            end
        end
        return acc;
    endfunction

endpackage

// File: design/ors_core.sv
// ----------------------------------------------------------------------------
// ors_core
// search state and per-beat decision: command, direction bit, rom and crc
// ----------------------------------------------------------------------------
module ors_core
    import ors_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  logic    operation,
    input  logic    restart,
    input  logic    presence,
    input  logic    conditional,
    input  logic    id_bit,
    input  logic    complement_bit,
    output result_t result
);

    logic [ROM_W-1:0] rom_reg, rom_next;
    logic [POS_W-1:0] last_disc_reg, last_disc_next;
    logic             done_reg, done_next;
    logic             active_reg, active_next;
    logic [POS_W-1:0] bit_pos_reg, bit_pos_next;
    logic [POS_W-1:0] marker_reg, marker_next;
    logic [7:0]       crc_reg, crc_next;

    logic [POS_W-1:0] last_disc_tmp;
    logic             done_tmp;
    logic [IDX_W-1:0] idx;
    logic             dir;

    always_comb
    begin
        rom_next       = rom_reg;
        last_disc_next = last_disc_reg;
        done_next      = done_reg;
        active_next    = active_reg;
        bit_pos_next   = bit_pos_reg;
        marker_next    = marker_reg;
        crc_next       = crc_reg;
        result         = '{kind: KIND_IGNORED, command_byte: 8'h00, write_bit: 1'b0,
                           rom_id: '0};
        idx            = bit_pos_reg[IDX_W-1:0] - IDX_W'(1);
        dir            = 1'b0;
        last_disc_tmp  = restart ? '0 : last_disc_reg;
        done_tmp       = restart ? 1'b0 : done_reg;

        if (!operation)
        begin
            done_next = done_tmp;
            if (!presence || done_tmp)
            begin
                last_disc_next = '0;
                active_next    = 1'b0;
                result.kind    = KIND_FAIL;
            end
            else
            begin
                last_disc_next      = last_disc_tmp;
                active_next         = 1'b1;
                bit_pos_next        = POS_W'(1);
                marker_next         = '0;
                crc_next            = 8'h00;
                result.kind         = KIND_COMMAND;
                result.command_byte = conditional ? CMD_COND_SEARCH : CMD_SEARCH;
            end
        end
        else if (!active_reg)
        begin
            result.kind = KIND_IGNORED;
        end
        else if (id_bit && complement_bit)
        begin
            last_disc_next = '0;
            active_next    = 1'b0;
            result.kind    = KIND_FAIL;
        end
        else
        begin
            // discrepancy when both slots read zero
            if (id_bit || complement_bit)
            begin
                dir = id_bit;
            end
            else
            begin
                if (bit_pos_reg < last_disc_reg)
                begin
                    dir = rom_reg[idx];
                end
                else
                begin
                    dir = (bit_pos_reg == last_disc_reg);
                end
                if (!dir)
                begin
                    marker_next = bit_pos_reg;
                end
            end
            rom_next[idx] = dir;
            if (idx[2:0] == 3'b111)
            begin
                crc_next = crc_byte(rom_next[{idx[IDX_W-1:3], 3'b000} +: 8], crc_reg);
            end
            bit_pos_next     = bit_pos_reg + POS_W'(1);
            result.write_bit = dir;
            if (idx != {IDX_W{1'b1}})
            begin
                result.kind = KIND_WRITE;
            end
            else
            begin
                active_next = 1'b0;
                if (crc_next != 8'h00)
                begin
                    last_disc_next = '0;
                    result.kind    = KIND_FAIL;
                end
                else
                begin
                    last_disc_next = marker_next;
                    done_next      = (marker_next == '0);
                    result.kind    = KIND_FOUND;
                    result.rom_id  = rom_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg       <= '0;
            last_disc_reg <= '0;
            done_reg      <= 1'b0;
            active_reg    <= 1'b0;
            bit_pos_reg   <= POS_W'(1);
            marker_reg    <= '0;
            crc_reg       <= 8'h00;
        end
        else if (take)
        begin
            rom_reg       <= rom_next;
            last_disc_reg <= last_disc_next;
            done_reg      <= done_next;
            active_reg    <= active_next;
            bit_pos_reg   <= bit_pos_next;
            marker_reg    <= marker_next;
            crc_reg       <= crc_next;
        end
    end

    a_done_no_disc: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (last_disc_reg == '0))
        else $error("search done with nonzero last discrepancy");

    a_found_ends_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (take && result.kind == KIND_FOUND) |=> !active_reg)
        else $error("pass still active after device found");

    a_command_opens_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (take && result.kind == KIND_COMMAND) |=> (active_reg && bit_pos_reg == POS_W'(1)))
        else $error("command beat did not open a pass at bit one");

endmodule

// File: design/ors_outbuf.sv
// ----------------------------------------------------------------------------
// ors_outbuf
// result register with a skid entry so input and output stall are decoupled
// ----------------------------------------------------------------------------
module ors_outbuf
    import ors_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

endmodule

// File: design/onewire_rom_search_engine.sv
// ----------------------------------------------------------------------------
// onewire_rom_search_engine
// 1-wire rom search decision engine, one bus event per beat
// ----------------------------------------------------------------------------
// One input beat is accepted per clock while item_stall is low, and its single
// result beat is registered. The decision for a beat is one pass
// of logic over the search state (compare, bit set, crc-8 byte update at each
// eighth bit). A skid entry behind the result register keeps the input side
// accepting for one more beat while the result side stalls; item_stall rises
// only when both result and skid entries are full.
// ----------------------------------------------------------------------------
module onewire_rom_search_engine
    import ors_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        operation,
    input  logic        restart,
    input  logic        presence,
    input  logic        conditional,
    input  logic        id_bit,
    input  logic        complement_bit,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  kind,
    output logic [7:0]  command_byte,
    output logic        write_bit,
    output logic [63:0] rom_id
);

    logic    take;
    logic    full;
    result_t core_result;
    result_t buf_result;

    assign take       = item_valid && !full;
    assign item_stall = full;

    ors_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .operation      (operation),
        .restart        (restart),
        .presence       (presence),
        .conditional    (conditional),
        .id_bit         (id_bit),
        .complement_bit (complement_bit),
        .result         (core_result)
    );

    ors_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (core_result),
        .full      (full),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (buf_result)
    );

    assign kind         = buf_result.kind;
    assign command_byte = buf_result.command_byte;
    assign write_bit    = buf_result.write_bit;
    assign rom_id       = buf_result.rom_id;

endmodule
